@@ hw/rtl/mgmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mgmc_pkg;

    // Event codes carried in the slave-side tuser
    typedef enum logic [2:0] {
        FUNC_SET_MODE  = 3'd0,
        FUNC_REQUEST   = 3'd1,
        FUNC_RELEASE   = 3'd2,
        FUNC_BEGIN_WR  = 3'd3,
        FUNC_END_WR    = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_EAGER    = 3'd1,
        MODE_LAME     = 3'd2,
        MODE_SHUTDOWN = 3'd3,
        MODE_DISABLED = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_MOUNT   = 2'd1,
        CMD_UNMOUNT = 2'd2
    } t_cmd;

    localparam int FUNC_W   = 3;
    localparam int MODE_W   = 3;
    localparam int REPORT_W = 8;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 24;

    // Mode and mount flag, kept together as the device-side state
    typedef struct packed {
        t_mode mode;
        logic  mounted;
    } t_ctl;

    // Per-event status flags reported with the result
    typedef struct packed {
        logic granted;
        t_cmd cmd;
        logic err;
    } t_flags;

endpackage

`default_nettype wire

@@ hw/rtl/mgmc_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mgmc_step #(
    parameter int MAX_COUNT = 255,
    parameter int CW        = 8
) (
    input  wire logic [mgmc_pkg::FUNC_W-1:0] i_func,
    input  wire logic [mgmc_pkg::MODE_W-1:0] i_new_mode,
    input  wire logic                        i_forced,
    input  wire logic                        i_mount_ok,
    input  wire mgmc_pkg::t_ctl              i_ctl,
    input  wire logic [CW-1:0]               i_holders,
    input  wire logic [CW-1:0]               i_forced_holders,
    input  wire logic [CW-1:0]               i_writes,
    output mgmc_pkg::t_ctl                   o_ctl,
    output logic [CW-1:0]                    o_holders,
    output logic [CW-1:0]                    o_forced_holders,
    output logic [CW-1:0]                    o_writes,
    output mgmc_pkg::t_flags                 o_flags
);
    import mgmc_pkg::*;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_COUNT);

    logic          admit;
    logic          idle;
    logic [CW-1:0] h_dec;
    logic [CW-1:0] f_dec;

    always_comb begin
        admit = !(i_ctl.mode == MODE_DISABLED || i_ctl.mode == MODE_SHUTDOWN)
                && !(i_ctl.mode == MODE_LAME && !i_forced);
        idle  = i_ctl.mounted && (i_holders == '0);
        h_dec = i_holders - CW'(1);
        f_dec = i_forced_holders;

        o_ctl            = i_ctl;
        o_holders        = i_holders;
        o_forced_holders = i_forced_holders;
        o_writes         = i_writes;
        o_flags          = '{granted: 1'b0, cmd: CMD_NONE, err: 1'b0};

        unique case (i_func)
            FUNC_SET_MODE: begin
                if (i_new_mode <= MODE_DISABLED && i_new_mode != i_ctl.mode) begin
                    unique case (i_new_mode)
                        MODE_NORMAL: begin
                            if (!i_ctl.mounted && i_holders != '0)
                                o_flags.cmd = CMD_MOUNT;
                        end
                        MODE_EAGER: begin
                            if (idle)
                                o_flags.cmd = CMD_UNMOUNT;
                            else if (!i_ctl.mounted && i_holders != '0)
                                o_flags.cmd = CMD_MOUNT;
                        end
                        MODE_LAME: begin
                            if (!i_ctl.mounted && i_forced_holders != '0)
                                o_flags.cmd = CMD_MOUNT;
                            else if (idle)
                                o_flags.cmd = CMD_UNMOUNT;
                        end
                        MODE_SHUTDOWN: begin
                            if (idle)
                                o_flags.cmd = CMD_UNMOUNT;
                        end
                        default: begin
                            // disabled drops the device regardless of holders
                            if (i_ctl.mounted)
                                o_flags.cmd = CMD_UNMOUNT;
                        end
                    endcase
                    if (o_flags.cmd == CMD_MOUNT)
                        o_ctl.mounted = i_mount_ok;
                    else if (o_flags.cmd == CMD_UNMOUNT)
                        o_ctl.mounted = 1'b0;
                    o_ctl.mode = t_mode'(i_new_mode);
                end
            end
            FUNC_REQUEST: begin
                if (admit && i_holders < CNT_MAX) begin
                    if (!i_ctl.mounted) begin
                        o_flags.cmd   = CMD_MOUNT;
                        o_ctl.mounted = i_mount_ok;
                    end
                    if (o_ctl.mounted) begin
                        o_holders       = i_holders + CW'(1);
                        o_flags.granted = 1'b1;
                        if (i_forced && i_forced_holders < CNT_MAX)
                            o_forced_holders = i_forced_holders + CW'(1);
                    end
                end
            end
            FUNC_RELEASE: begin
                if (i_holders == '0) begin
                    o_flags.err = 1'b1;
                end else begin
                    o_holders = h_dec;
                    if (i_forced) begin
                        if (i_forced_holders != '0)
                            f_dec = i_forced_holders - CW'(1);
                        else
                            o_flags.err = 1'b1;
                    end
                    o_forced_holders = (f_dec > h_dec) ? h_dec : f_dec;
                    if (i_ctl.mounted && h_dec == '0 && i_ctl.mode != MODE_NORMAL) begin
                        o_flags.cmd   = CMD_UNMOUNT;
                        o_ctl.mounted = 1'b0;
                    end
                end
            end
            FUNC_BEGIN_WR: begin
                if (i_ctl.mounted && admit && i_writes < CNT_MAX) begin
                    o_writes        = i_writes + CW'(1);
                    o_flags.granted = 1'b1;
                end
            end
            FUNC_END_WR: begin
                if (i_writes == '0)
                    o_flags.err = 1'b1;
                else
                    o_writes = i_writes - CW'(1);
            end
            default: begin
                // unused event codes only report the status
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/mount_guard_mode_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: new_mode, forced, mount_ok
//                                            tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: granted .. count_error
//
// One event per cycle while m_axis is not stalled. The step logic reads the
// state registers and the incoming transaction and writes the new state and
// the result register in the same edge, so the result shows in the cycle after
// the event is accepted. Reset (i_rst_n low, synchronous) returns to normal
// mode, unmounted, zero counts, and empties the result register. A stall on
// m_axis holds the result; s_axis_tready stays high while the result register
// is empty or being drained in the same cycle.

module mount_guard_mode_controller #(
    parameter int MAX_COUNT = 255
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [2:0] new_mode, [3] forced, [4] mount_ok, [7:5] zero
    input  wire logic [mgmc_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [2:0] func
    input  wire logic [mgmc_pkg::FUNC_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [0] granted, [2:1] device_command, [3] is_mounted, [6:4] current_mode,
    // [14:7] pending_mounts, [22:15] pending_writes, [23] count_error
    output logic [mgmc_pkg::M_DATA_W-1:0]      m_axis_tdata
);
    import mgmc_pkg::*;

    // counter width follows the saturation limit
    localparam int CW = $clog2(MAX_COUNT + 1);

    // device state
    t_ctl          r_ctl,     n_ctl;
    logic [CW-1:0] r_holders, n_holders;
    logic [CW-1:0] r_fholders, n_fholders;
    logic [CW-1:0] r_writes,  n_writes;
    t_flags        n_flags;

    // result register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic s_fire;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    mgmc_step #(
        .MAX_COUNT (MAX_COUNT),
        .CW        (CW)
    ) u_step (
        .i_func           (s_axis_tuser),
        .i_new_mode       (s_axis_tdata[2:0]),
        .i_forced         (s_axis_tdata[3]),
        .i_mount_ok       (s_axis_tdata[4]),
        .i_ctl            (r_ctl),
        .i_holders        (r_holders),
        .i_forced_holders (r_fholders),
        .i_writes         (r_writes),
        .o_ctl            (n_ctl),
        .o_holders        (n_holders),
        .o_forced_holders (n_fholders),
        .o_writes         (n_writes),
        .o_flags          (n_flags)
    );

    // state only moves on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= '{mode: MODE_NORMAL, mounted: 1'b0};
            r_holders  <= '0;
            r_fholders <= '0;
            r_writes   <= '0;
        end else if (s_fire) begin
            r_ctl      <= n_ctl;
            r_holders  <= n_holders;
            r_fholders <= n_fholders;
            r_writes   <= n_writes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // reported counts are the low byte of the counters
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_data <= {n_flags.err,
                           REPORT_W'(n_writes),
                           REPORT_W'(n_holders),
                           n_ctl.mode,
                           n_ctl.mounted,
                           n_flags.cmd,
                           n_flags.granted};
        end
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import mgmc_pkg::*;

    localparam int MAX_COUNT = 255;

    // One slave-side transaction: func rides in tuser, the rest in tdata
    typedef struct packed {
        logic [2:0] func;
        logic [2:0] new_mode;
        logic       forced;
        logic       mount_ok;
    } t_guard_event;

    // Master-side tdata layout, lowest bit last
    typedef struct packed {
        logic       err;      // [23]
        logic [7:0] writes;   // [22:15]
        logic [7:0] mounts;   // [14:7]
        logic [2:0] mode;     // [6:4]
        logic       mounted;  // [3]
        logic [1:0] cmd;      // [2:1]
        logic       granted;  // [0]
    } t_guard_status;

    // Directed script row; typed rows carry a hand-written expectation
    typedef struct {
        t_guard_event  ev;
        bit            typed;
        t_guard_status want;
    } t_script_row;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    wire logic           s_axis_tready;
    // [2:0] new_mode, [3] forced, [4] mount_ok, [7:5] zero
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    // [2:0] func
    logic [FUNC_W-1:0]   s_axis_tuser  = '0;
    wire logic           m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [0] granted, [2:1] device_command, [3] is_mounted, [6:4] current_mode,
    // [14:7] pending_mounts, [22:15] pending_writes, [23] count_error
    wire logic [M_DATA_W-1:0] m_axis_tdata;

    mount_guard_mode_controller #(.MAX_COUNT(MAX_COUNT)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Guard state as the testbench sees it
    t_mode       g_mode    = MODE_NORMAL;
    logic        g_mounted = 1'b0;
    logic [7:0]  g_holders = '0;
    logic [7:0]  g_forced  = '0;
    logic [7:0]  g_writes  = '0;

    t_guard_status status_q[$];     // expected results, oldest first
    t_script_row   script_q[$];
    int            fail_count = 0;
    int            gap_pct    = 0;  // sender idle chance per cycle
    int            stall_pct  = 0;  // receiver stall chance per cycle

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic bit admits(input logic forced);
        if (g_mode == MODE_DISABLED || g_mode == MODE_SHUTDOWN) return 1'b0;
        if (g_mode == MODE_LAME && !forced) return 1'b0;
        return 1'b1;
    endfunction

    // Advance the guard state by one event and return the status it reports
    function automatic t_guard_status step_guard(input t_guard_event ev);
        t_guard_status r;
        logic          idle;
        r = '0;
        case (ev.func)
            FUNC_SET_MODE: begin
                // Unknown targets and same-mode sets are no-ops
                if (ev.new_mode <= MODE_DISABLED && ev.new_mode != g_mode) begin
                    idle = g_mounted && g_holders == 0;
                    case (ev.new_mode)
                        MODE_NORMAL: begin
                            if (!g_mounted && g_holders != 0) r.cmd = CMD_MOUNT;
                        end
                        MODE_EAGER: begin
                            if (idle) r.cmd = CMD_UNMOUNT;
                            else if (!g_mounted && g_holders != 0) r.cmd = CMD_MOUNT;
                        end
                        MODE_LAME: begin
                            if (!g_mounted && g_forced != 0) r.cmd = CMD_MOUNT;
                            else if (idle) r.cmd = CMD_UNMOUNT;
                        end
                        MODE_SHUTDOWN: begin
                            if (idle) r.cmd = CMD_UNMOUNT;
                        end
                        default: begin
                            if (g_mounted) r.cmd = CMD_UNMOUNT;
                        end
                    endcase
                    if (r.cmd == CMD_MOUNT) g_mounted = ev.mount_ok;
                    else if (r.cmd == CMD_UNMOUNT) g_mounted = 1'b0;
                    g_mode = t_mode'(ev.new_mode);
                end
            end
            FUNC_REQUEST: begin
                if (admits(ev.forced) && g_holders < MAX_COUNT) begin
                    if (!g_mounted) begin
                        r.cmd     = CMD_MOUNT;
                        g_mounted = ev.mount_ok;
                    end
                    if (g_mounted) begin
                        g_holders++;
                        if (ev.forced && g_forced < MAX_COUNT) g_forced++;
                        r.granted = 1'b1;
                    end
                end
            end
            FUNC_RELEASE: begin
                if (g_holders == 0) begin
                    r.err = 1'b1;
                end else begin
                    g_holders--;
                    if (ev.forced) begin
                        if (g_forced != 0) g_forced--;
                        else r.err = 1'b1;
                    end
                    // forced holders never outnumber holders
                    if (g_forced > g_holders) g_forced = g_holders;
                    if (g_mounted && g_holders == 0 && g_mode != MODE_NORMAL) begin
                        r.cmd     = CMD_UNMOUNT;
                        g_mounted = 1'b0;
                    end
                end
            end
            FUNC_BEGIN_WR: begin
                if (g_mounted && admits(ev.forced) && g_writes < MAX_COUNT) begin
                    g_writes++;
                    r.granted = 1'b1;
                end
            end
            FUNC_END_WR: begin
                if (g_writes == 0) r.err = 1'b1;
                else g_writes--;
            end
            default: ;  // unknown func: status only
        endcase
        r.mounted = g_mounted;
        r.mode    = g_mode;
        r.mounts  = g_holders;
        r.writes  = g_writes;
        return r;
    endfunction

    task automatic add_row(input logic [2:0] func, input logic [2:0] new_mode,
                           input logic forced, input logic mount_ok,
                           input bit typed, input t_guard_status want);
        t_script_row row;
        row.ev    = '{func: func, new_mode: new_mode, forced: forced,
                      mount_ok: mount_ok};
        row.typed = typed;
        row.want  = want;
        script_q.push_back(row);
    endtask

    // Random event; fill mode leans on requests so that the holder count
    // climbs to saturation
    function automatic t_guard_event random_event(input bit fill);
        t_guard_event ev;
        int           pick;
        pick        = $urandom_range(0, 99);
        ev.forced   = 1'($urandom_range(0, 1));
        ev.mount_ok = $urandom_range(0, 99) < 75;
        ev.new_mode = 3'($urandom_range(0, 7));
        if (fill && pick < 96) begin
            ev.func     = FUNC_REQUEST;
            ev.mount_ok = $urandom_range(0, 99) < 90;
        end else if (fill) begin
            ev.func = FUNC_BEGIN_WR;
        end else begin
            // mostly legal funcs, now and then an undefined code
            ev.func = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                   : 3'($urandom_range(0, 7));
            if (ev.func == FUNC_SET_MODE && $urandom_range(0, 99) < 85)
                ev.new_mode = 3'($urandom_range(0, 4));
        end
        return ev;
    endfunction

    // Drive one transaction and record its expectation on acceptance
    task automatic send_event(input t_guard_event ev, input bit typed,
                              input t_guard_status want);
        t_guard_status pred;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ev.mount_ok, ev.forced, ev.new_mode};
        s_axis_tuser  <= ev.func;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = step_guard(ev);
        status_q.push_back(typed ? want : pred);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_status(input t_guard_status got);
        t_guard_status want;
        if (status_q.size() == 0) begin
            $error("unexpected result transaction: %h", got);
            fail_count++;
        end else begin
            want = status_q.pop_front();
            compare_field("granted", want.granted, got.granted);
            compare_field("device_command", want.cmd, got.cmd);
            compare_field("is_mounted", want.mounted, got.mounted);
            compare_field("current_mode", want.mode, got.mode);
            compare_field("pending_mounts", want.mounts, got.mounts);
            compare_field("pending_writes", want.writes, got.writes);
            compare_field("count_error", want.err, got.err);
        end
    endtask

    // Receiver: check accepted results, then pick next cycle's tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_status(t_guard_status'(m_axis_tdata));
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        int gap_tab[4];
        int stall_tab[4];
        t_guard_status none;
        none         = '0;
        gap_tab      = '{0, 84, 0, 26};
        stall_tab    = '{0, 0, 84, 26};

        // Directed script, starting from the reset state.
        // Typed rows: releases/ends at zero, write while unmounted,
        // a refused mount answer and the first good mount.
        add_row(FUNC_RELEASE, MODE_NORMAL, 1'b0, 1'b0, 1'b1, '{err: 1'b1, default: '0});
        add_row(FUNC_END_WR, MODE_NORMAL, 1'b0, 1'b0, 1'b1, '{err: 1'b1, default: '0});
        add_row(FUNC_BEGIN_WR, MODE_NORMAL, 1'b1, 1'b1, 1'b1, none);
        add_row(FUNC_REQUEST, MODE_NORMAL, 1'b0, 1'b0, 1'b1,
                '{cmd: CMD_MOUNT, default: '0});
        add_row(FUNC_REQUEST, MODE_NORMAL, 1'b1, 1'b1, 1'b1,
                '{granted: 1'b1, cmd: CMD_MOUNT, mounted: 1'b1, mounts: 8'd1,
                  default: '0});
        // Predicted rows
        add_row(FUNC_BEGIN_WR, MODE_NORMAL, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_SET_MODE, 3'd7, 1'b1, 1'b1, 1'b0, none);     // unknown mode
        add_row(3'd7, 3'd7, 1'b1, 1'b1, 1'b0, none);               // unknown func
        add_row(3'd5, MODE_DISABLED, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_SET_MODE, MODE_LAME, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_REQUEST, MODE_NORMAL, 1'b0, 1'b1, 1'b0, none); // lame: refused
        add_row(FUNC_REQUEST, MODE_NORMAL, 1'b1, 1'b1, 1'b0, none); // lame: forced ok
        add_row(FUNC_RELEASE, MODE_NORMAL, 1'b0, 1'b0, 1'b0, none); // non-forced release
        add_row(FUNC_RELEASE, MODE_NORMAL, 1'b0, 1'b0, 1'b0, none); // last holder, forced clamps
        add_row(FUNC_SET_MODE, MODE_NORMAL, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_REQUEST, MODE_NORMAL, 1'b0, 1'b1, 1'b0, none);
        add_row(FUNC_SET_MODE, MODE_EAGER, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_SET_MODE, MODE_SHUTDOWN, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_REQUEST, MODE_NORMAL, 1'b1, 1'b1, 1'b0, none);
        add_row(FUNC_BEGIN_WR, MODE_NORMAL, 1'b1, 1'b1, 1'b0, none);
        add_row(FUNC_RELEASE, MODE_NORMAL, 1'b1, 1'b0, 1'b0, none); // no forced holder
        add_row(FUNC_END_WR, MODE_NORMAL, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_SET_MODE, MODE_DISABLED, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_SET_MODE, MODE_NORMAL, 1'b0, 1'b0, 1'b0, none);
        add_row(FUNC_REQUEST, MODE_NORMAL, 1'b1, 1'b1, 1'b0, none);
        add_row(FUNC_SET_MODE, MODE_DISABLED, 1'b0, 1'b0, 1'b0, none); // unmount

        // Single reset at the start of the run
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script_q[i])
            send_event(script_q[i].ev, script_q[i].typed, script_q[i].want);

        // Random mix under each idling pattern
        for (int p = 0; p < 4; p++) begin
            gap_pct   = gap_tab[p];
            stall_pct = stall_tab[p];
            repeat (25) send_event(random_event(1'b0), 1'b0, none);
        end

        // Fill run: back to normal, then climb the holder count to saturation and keep requesting
        gap_pct   = 26;
        stall_pct = 26;
        send_event('{func: FUNC_SET_MODE, new_mode: MODE_NORMAL, forced: 1'b0,
                     mount_ok: 1'b1}, 1'b0, none);
        repeat (280) send_event(random_event(1'b1), 1'b0, none);

        s_axis_tvalid <= 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ mount_guard_mode_controller.f @@
hw/rtl/mgmc_pkg.sv
hw/rtl/mgmc_step.sv
hw/rtl/mount_guard_mode_controller.sv
verif/testbench.sv
